FILE: src/cssr_pkg.sv
// ----------------------------------------------------------------------------
// cssr_pkg: shared types and constants for the clock-source slot registry
// Command and status codes, slot-cell interface records and the FSM encoding.
// ----------------------------------------------------------------------------
package cssr_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int ID_W      = 4;
    localparam int KEY_W     = 32;
    localparam int TIME_W    = 48;
    localparam int TMO_W     = 24;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 24'd1500000;

    localparam logic [2:0] CMD_CLAIM  = 3'd0;
    localparam logic [2:0] CMD_FREE   = 3'd1;
    localparam logic [2:0] CMD_LIVE   = 3'd2;
    localparam logic [2:0] CMD_XPORT  = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;
    localparam logic [2:0] CMD_LOOKUP = 3'd5;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_BADSLOT = 2'd2;

    typedef enum logic [2:0] {
        OP_CLAIM,
        OP_REVIVE,
        OP_FREE,
        OP_LIVE,
        OP_XPORT
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PRIM = 3'b100
    } state_t;

    // write to one slot, broadcast to every cell
    typedef struct packed {
        logic              valid;
        op_t               op;
        logic [ID_W-1:0]   target;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
    } apply_t;

    // request context seen by every cell during a scan
    typedef struct packed {
        logic              tick;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic [TMO_W-1:0]  timeout;
    } bcast_t;

    // record handed from cell to cell along the chain
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   found;
        logic              found_stale;
        logic [ID_W-1:0]   free_idx;
        logic [ID_W-1:0]   old_idx;
        logic [TIME_W-1:0] old_time;
        logic [ID_W-1:0]   first_act;
        logic [ID_W-1:0]   first_live;
        logic              changed;
    } scan_t;

    typedef struct packed {
        logic active;
        logic stale;
    } slot_status_t;

endpackage

FILE: src/clock_source_slot_registry_core.sv
// ----------------------------------------------------------------------------
// clock_source_slot_registry_core: clock-source slot registry
// A row of slot cells scanned one cell per cycle by a request record, with a
// small controller that decides claims and recomputes the primary slot.
// ----------------------------------------------------------------------------
// Handshake: a request is taken when start is high and busy is low; its result
// appears on the result ports for one cycle with done high and must be taken
// then. Free-standing answers (feeds, bad slot numbers, key 0, unknown
// commands) come in the cycle after the request with busy never raised. Lookup,
// tick and a claim of a live held key send one record down the cell chain and
// answer when it leaves the last cell. Free costs one chain pass for the
// primary recompute; a claim that changes the registry costs two passes. Each
// pass walks the cell chain one cell per cycle.
// ----------------------------------------------------------------------------
module clock_source_slot_registry_core #(
    parameter int SLOTS = cssr_pkg::SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   cmd,
    input  logic [cssr_pkg::KEY_W-1:0]   port_key,
    input  logic [cssr_pkg::ID_W-1:0]    slot_id,
    input  logic [cssr_pkg::TIME_W-1:0]  now_us,
    input  logic                         cfg_we,
    input  logic [cssr_pkg::TMO_W-1:0]   cfg_wdata,
    output logic                         done,
    output logic [cssr_pkg::ID_W-1:0]    slot_out,
    output logic [1:0]                   status,
    output logic [cssr_pkg::ID_W-1:0]    primary_slot,
    output logic                         changed
);

    cssr_pkg::state_t               state_reg, state_next;
    logic                           launch_reg, launch_next;
    logic                           done_reg, done_next;
    logic [cssr_pkg::ID_W-1:0]      slot_out_reg, slot_out_next;
    logic [1:0]                     status_reg, status_next;
    logic                           changed_reg, changed_next;
    logic [cssr_pkg::ID_W-1:0]      primary_reg, primary_next;
    logic [cssr_pkg::ID_W-1:0]      pend_reg, pend_next;
    logic [2:0]                     cmd_reg, cmd_next;
    logic [cssr_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [cssr_pkg::TIME_W-1:0]    now_reg, now_next;
    logic [cssr_pkg::TMO_W-1:0]     timeout_reg;

    cssr_pkg::apply_t               ap;
    cssr_pkg::bcast_t               bc;
    cssr_pkg::scan_t                chain [0:SLOTS];
    cssr_pkg::slot_status_t         stat [0:SLOTS-1];
    cssr_pkg::scan_t                tail;
    logic [15:0]                    act16;
    logic [15:0]                    stale16;
    logic [cssr_pkg::ID_W-1:0]      tail_prim;
    logic [cssr_pkg::ID_W-1:0]      claim_tgt;

    assign chain[0] = '{valid: launch_reg, default: '0};

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            cssr_cell #(
                .IDX(cssr_pkg::ID_W'(g + 1))
            ) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .bc   (bc),
                .ap   (ap),
                .rin  (chain[g]),
                .rout (chain[g+1]),
                .st   (stat[g])
            );
        end
    endgenerate

    // slot numbers index directly; bit 0 and bits above SLOTS read as inactive
    always_comb
    begin
        act16   = '0;
        stale16 = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            act16[i+1]   = stat[i].active;
            stale16[i+1] = stat[i].stale;
        end
    end

    assign bc.tick    = (cmd_reg == cssr_pkg::CMD_TICK);
    assign bc.key     = key_reg;
    assign bc.now     = now_reg;
    assign bc.timeout = timeout_reg;

    assign tail      = chain[SLOTS];
    assign tail_prim = (tail.first_live != '0) ? tail.first_live : tail.first_act;
    assign claim_tgt = (tail.free_idx != '0) ? tail.free_idx : tail.old_idx;

    always_comb
    begin
        state_next    = state_reg;
        launch_next   = 1'b0;
        done_next     = 1'b0;
        slot_out_next = slot_out_reg;
        status_next   = status_reg;
        changed_next  = changed_reg;
        primary_next  = primary_reg;
        pend_next     = pend_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        now_next      = now_reg;
        ap            = '0;

        case (state_reg)
            cssr_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    key_next = port_key;
                    now_next = now_us;
                    case (cmd)
                        cssr_pkg::CMD_CLAIM, cssr_pkg::CMD_LOOKUP:
                        begin
                            if (port_key == '0)
                            begin
                                done_next     = 1'b1;
                                slot_out_next = '0;
                                status_next   = cssr_pkg::STAT_FULL;
                                changed_next  = 1'b0;
                            end
                            else
                            begin
                                state_next  = cssr_pkg::S_SCAN;
                                launch_next = 1'b1;
                            end
                        end
                        cssr_pkg::CMD_TICK:
                        begin
                            state_next  = cssr_pkg::S_SCAN;
                            launch_next = 1'b1;
                        end
                        cssr_pkg::CMD_FREE, cssr_pkg::CMD_LIVE, cssr_pkg::CMD_XPORT:
                        begin
                            if (!act16[slot_id])
                            begin
                                done_next     = 1'b1;
                                slot_out_next = '0;
                                status_next   = cssr_pkg::STAT_BADSLOT;
                                changed_next  = 1'b0;
                            end
                            else
                            begin
                                ap.valid  = 1'b1;
                                ap.target = slot_id;
                                ap.key    = port_key;
                                ap.now    = now_us;
                                if (cmd == cssr_pkg::CMD_FREE)
                                begin
                                    ap.op       = cssr_pkg::OP_FREE;
                                    pend_next   = '0;
                                    state_next  = cssr_pkg::S_PRIM;
                                    launch_next = 1'b1;
                                end
                                else
                                begin
                                    // live feed announces a revival, primary left as is
                                    ap.op = (cmd == cssr_pkg::CMD_LIVE) ? cssr_pkg::OP_LIVE
                                                                       : cssr_pkg::OP_XPORT;
                                    done_next     = 1'b1;
                                    slot_out_next = '0;
                                    status_next   = cssr_pkg::STAT_OK;
                                    changed_next  = (cmd == cssr_pkg::CMD_LIVE)
                                                    && stale16[slot_id];
                                end
                            end
                        end
                        default:
                        begin
                            done_next     = 1'b1;
                            slot_out_next = '0;
                            status_next   = cssr_pkg::STAT_OK;
                            changed_next  = 1'b0;
                        end
                    endcase
                end
            end

            cssr_pkg::S_SCAN:
            begin
                if (tail.valid)
                begin
                    ap.key = key_reg;
                    ap.now = now_reg;
                    case (cmd_reg)
                        cssr_pkg::CMD_LOOKUP:
                        begin
                            done_next     = 1'b1;
                            slot_out_next = tail.found;
                            status_next   = cssr_pkg::STAT_OK;
                            changed_next  = 1'b0;
                            state_next    = cssr_pkg::S_IDLE;
                        end
                        cssr_pkg::CMD_TICK:
                        begin
                            if (tail.changed)
                                primary_next = tail_prim;
                            done_next     = 1'b1;
                            slot_out_next = '0;
                            status_next   = cssr_pkg::STAT_OK;
                            changed_next  = tail.changed;
                            state_next    = cssr_pkg::S_IDLE;
                        end
                        default:
                        begin
                            if (tail.found != '0)
                            begin
                                if (tail.found_stale)
                                begin
                                    ap.valid    = 1'b1;
                                    ap.op       = cssr_pkg::OP_REVIVE;
                                    ap.target   = tail.found;
                                    pend_next   = tail.found;
                                    state_next  = cssr_pkg::S_PRIM;
                                    launch_next = 1'b1;
                                end
                                else
                                begin
                                    done_next     = 1'b1;
                                    slot_out_next = tail.found;
                                    status_next   = cssr_pkg::STAT_OK;
                                    changed_next  = 1'b0;
                                    state_next    = cssr_pkg::S_IDLE;
                                end
                            end
                            else if (claim_tgt == '0)
                            begin
                                // every slot live
                                done_next     = 1'b1;
                                slot_out_next = '0;
                                status_next   = cssr_pkg::STAT_FULL;
                                changed_next  = 1'b0;
                                state_next    = cssr_pkg::S_IDLE;
                            end
                            else
                            begin
                                ap.valid    = 1'b1;
                                ap.op       = cssr_pkg::OP_CLAIM;
                                ap.target   = claim_tgt;
                                pend_next   = claim_tgt;
                                state_next  = cssr_pkg::S_PRIM;
                                launch_next = 1'b1;
                            end
                        end
                    endcase
                end
            end

            cssr_pkg::S_PRIM:
            begin
                if (tail.valid)
                begin
                    primary_next  = tail_prim;
                    done_next     = 1'b1;
                    slot_out_next = pend_reg;
                    status_next   = cssr_pkg::STAT_OK;
                    changed_next  = 1'b1;
                    state_next    = cssr_pkg::S_IDLE;
                end
            end

            default:
                state_next = cssr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cssr_pkg::S_IDLE;
            launch_reg  <= 1'b0;
            done_reg    <= 1'b0;
            primary_reg <= '0;
            timeout_reg <= cssr_pkg::TIMEOUT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            done_reg    <= done_next;
            primary_reg <= primary_next;
            if (cfg_we)
                timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_out_reg <= slot_out_next;
        status_reg   <= status_next;
        changed_reg  <= changed_next;
        pend_reg     <= pend_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        now_reg      <= now_next;
    end

    assign busy         = (state_reg != cssr_pkg::S_IDLE);
    assign done         = done_reg;
    assign slot_out     = slot_out_reg;
    assign status       = status_reg;
    assign changed      = changed_reg;
    assign primary_slot = primary_reg;

endmodule

FILE: src/cssr_cell.sv
// ----------------------------------------------------------------------------
// cssr_cell: one clock-source slot
// Holds the slot state, folds itself into the passing scan record and takes
// writes addressed to its slot number.
// ----------------------------------------------------------------------------
module cssr_cell #(
    parameter logic [cssr_pkg::ID_W-1:0] IDX = 4'd1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cssr_pkg::bcast_t       bc,
    input  cssr_pkg::apply_t       ap,
    input  cssr_pkg::scan_t        rin,
    output cssr_pkg::scan_t        rout,
    output cssr_pkg::slot_status_t st
);

    logic                            active_reg;
    logic                            stale_reg;
    logic [cssr_pkg::KEY_W-1:0]      key_reg;
    logic [cssr_pkg::TIME_W-1:0]     last_reg;
    logic [cssr_pkg::TIME_W-1:0]     wsa_reg;
    cssr_pkg::scan_t                 rout_reg;
    cssr_pkg::scan_t                 rout_next;
    logic                            tick_hit;
    logic                            stale_post;
    logic                            hit;
    logic [cssr_pkg::TIME_W-1:0]     age;

    assign age = bc.now - last_reg;
    assign tick_hit = bc.tick && rin.valid && active_reg && !stale_reg
                      && (bc.now >= last_reg)
                      && (age > {{(cssr_pkg::TIME_W-cssr_pkg::TMO_W){1'b0}}, bc.timeout});
    assign stale_post = stale_reg | tick_hit;
    assign hit = ap.valid && (ap.target == IDX);

    always_comb
    begin
        rout_next = rin;
        if (rin.valid)
        begin
            if (active_reg && (key_reg == bc.key) && (rin.found == '0))
            begin
                rout_next.found       = IDX;
                rout_next.found_stale = stale_reg;
            end
            if (!active_reg && (rin.free_idx == '0))
                rout_next.free_idx = IDX;
            // ties keep the lower slot
            if (active_reg && stale_reg && ((rin.old_idx == '0) || (wsa_reg < rin.old_time)))
            begin
                rout_next.old_idx  = IDX;
                rout_next.old_time = wsa_reg;
            end
            if (tick_hit)
                rout_next.changed = 1'b1;
            if (active_reg && (rin.first_act == '0))
                rout_next.first_act = IDX;
            if (active_reg && !stale_post && (rin.first_live == '0))
                rout_next.first_live = IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            stale_reg  <= 1'b0;
            rout_reg   <= '0;
        end
        else
        begin
            rout_reg <= rout_next;
            if (hit)
            begin
                case (ap.op)
                    cssr_pkg::OP_CLAIM:
                    begin
                        active_reg <= 1'b1;
                        stale_reg  <= 1'b0;
                    end
                    cssr_pkg::OP_REVIVE, cssr_pkg::OP_LIVE:
                        stale_reg <= 1'b0;
                    cssr_pkg::OP_FREE:
                    begin
                        active_reg <= 1'b0;
                        stale_reg  <= 1'b0;
                    end
                    default:
                        ;
                endcase
            end
            else if (tick_hit)
                stale_reg <= 1'b1;
        end
    end

    // slot payload, no reset
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            case (ap.op)
                cssr_pkg::OP_CLAIM:
                begin
                    key_reg  <= ap.key;
                    last_reg <= ap.now;
                    wsa_reg  <= '0;
                end
                cssr_pkg::OP_REVIVE, cssr_pkg::OP_LIVE, cssr_pkg::OP_XPORT:
                    last_reg <= ap.now;
                cssr_pkg::OP_FREE:
                begin
                    key_reg  <= '0;
                    last_reg <= '0;
                    wsa_reg  <= '0;
                end
                default:
                    ;
            endcase
        end
        else if (tick_hit)
            wsa_reg <= bc.now;
    end

    assign rout      = rout_reg;
    assign st.active = active_reg;
    assign st.stale  = stale_reg;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for clock_source_slot_registry_core
// Drives requests over start/busy from a short table and then at random,
// predicts every answer with a local model of the slot table and checks each
// done strobe against the oldest outstanding expected answer. The stale timeout is
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int SLOTS = cssr_pkg::SLOTS_DEF;
    localparam int ID_W = cssr_pkg::ID_W;
    localparam int KEY_W = cssr_pkg::KEY_W;
    localparam int TIME_W = cssr_pkg::TIME_W;
    localparam int TMO_W = cssr_pkg::TMO_W;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = cssr_pkg::TIMEOUT_RESET;
    localparam logic [2:0] CMD_CLAIM = cssr_pkg::CMD_CLAIM;
    localparam logic [2:0] CMD_FREE = cssr_pkg::CMD_FREE;
    localparam logic [2:0] CMD_LIVE = cssr_pkg::CMD_LIVE;
    localparam logic [2:0] CMD_XPORT = cssr_pkg::CMD_XPORT;
    localparam logic [2:0] CMD_TICK = cssr_pkg::CMD_TICK;
    localparam logic [2:0] CMD_LOOKUP = cssr_pkg::CMD_LOOKUP;
    localparam logic [1:0] STAT_OK = cssr_pkg::STAT_OK;
    localparam logic [1:0] STAT_FULL = cssr_pkg::STAT_FULL;
    localparam logic [1:0] STAT_BADSLOT = cssr_pkg::STAT_BADSLOT;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 170;
    localparam int SETTLE = 2 * SLOTS + 8;

    typedef struct packed {
        logic [ID_W-1:0] slot;
        logic [1:0]      status;
        logic [ID_W-1:0] primary;
        logic            changed;
    } answer_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic              typed;
        answer_t           ans;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [2:0]          cmd = '0;
    logic [KEY_W-1:0]    port_key = '0;
    logic [ID_W-1:0]     slot_id = '0;
    logic [TIME_W-1:0]   now_us = '0;
    logic                cfg_we = 1'b0;
    logic [TMO_W-1:0]    cfg_wdata = '0;
    logic                busy;
    logic                done;
    logic [ID_W-1:0]     slot_out;
    logic [1:0]          status;
    logic [ID_W-1:0]     primary_slot;
    logic                changed;

    // local copy of the registry
    logic [TMO_W-1:0]    mdl_timeout;
    logic                mdl_active [0:SLOTS-1];
    logic [KEY_W-1:0]    mdl_key [0:SLOTS-1];
    logic                mdl_stale [0:SLOTS-1];
    logic [TIME_W-1:0]   mdl_fed [0:SLOTS-1];
    logic [TIME_W-1:0]   mdl_stale_at [0:SLOTS-1];
    logic [ID_W-1:0]     mdl_primary;

    answer_t             pending_answers [$];
    stim_row_t           directed_rows [$];
    int                  mismatch_count = 0;
    bit                  burst_mode = 1'b0;

    clock_source_slot_registry_core #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .port_key(port_key),
        .slot_id(slot_id),
        .now_us(now_us),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .done(done),
        .slot_out(slot_out),
        .status(status),
        .primary_slot(primary_slot),
        .changed(changed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [ID_W-1:0] slot_of_key(logic [KEY_W-1:0] k);
        logic [ID_W-1:0] hit;
        hit = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (mdl_active[i] && mdl_key[i] == k)
                hit = ID_W'(i + 1);
        return hit;
    endfunction

    function automatic bit slot_in_use(logic [ID_W-1:0] id);
        return id >= 1 && id <= SLOTS && mdl_active[id - 1];
    endfunction

    // lowest live slot, else lowest active one
    function automatic void refresh_primary();
        logic [ID_W-1:0] first_act;
        logic [ID_W-1:0] first_live;
        first_act = '0;
        first_live = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (mdl_active[i])
            begin
                first_act = ID_W'(i + 1);
                if (!mdl_stale[i])
                    first_live = ID_W'(i + 1);
            end
        mdl_primary = (first_live != 0) ? first_live : first_act;
    endfunction

    task automatic registry_reset();
        mdl_timeout = TIMEOUT_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            mdl_active[i] = 1'b0;
            mdl_key[i] = '0;
            mdl_stale[i] = 1'b0;
            mdl_fed[i] = '0;
            mdl_stale_at[i] = '0;
        end
        mdl_primary = '0;
    endtask

    task automatic registry_predict(input logic [2:0] c, input logic [KEY_W-1:0] k,
                                    input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] now, output answer_t a);
        logic [ID_W-1:0]   s;
        bit                have_old;
        bit                got_free;
        logic [TIME_W-1:0] oldest;
        int                j;
        a = '0;
        j = int'(id) - 1;
        case (c)
            CMD_CLAIM:
            begin
                if (k == 0)
                    a.status = STAT_FULL;
                else
                begin
                    s = slot_of_key(k);
                    if (s == 0)
                    begin
                        have_old = 1'b0;
                        got_free = 1'b0;
                        oldest = '0;
                        // first free slot wins, else the earliest to go stale
                        for (int i = 0; i < SLOTS; i++)
                            if (!got_free)
                            begin
                                if (!mdl_active[i])
                                begin
                                    s = ID_W'(i + 1);
                                    got_free = 1'b1;
                                end
                                else if (mdl_stale[i] &&
                                         (!have_old || mdl_stale_at[i] < oldest))
                                begin
                                    have_old = 1'b1;
                                    oldest = mdl_stale_at[i];
                                    s = ID_W'(i + 1);
                                end
                            end
                        if (s == 0)
                            a.status = STAT_FULL;
                        else
                        begin
                            mdl_active[s - 1] = 1'b1;
                            mdl_key[s - 1] = k;
                            mdl_stale[s - 1] = 1'b0;
                            mdl_fed[s - 1] = now;
                            mdl_stale_at[s - 1] = '0;
                            refresh_primary();
                            a.changed = 1'b1;
                            a.slot = s;
                        end
                    end
                    else
                    begin
                        if (mdl_stale[s - 1])
                        begin
                            mdl_stale[s - 1] = 1'b0;
                            mdl_fed[s - 1] = now;
                            refresh_primary();
                            a.changed = 1'b1;
                        end
                        a.slot = s;
                    end
                end
            end
            CMD_FREE:
            begin
                if (!slot_in_use(id))
                    a.status = STAT_BADSLOT;
                else
                begin
                    mdl_active[j] = 1'b0;
                    mdl_key[j] = '0;
                    mdl_stale[j] = 1'b0;
                    mdl_fed[j] = '0;
                    mdl_stale_at[j] = '0;
                    refresh_primary();
                    a.changed = 1'b1;
                end
            end
            CMD_LIVE, CMD_XPORT:
            begin
                if (!slot_in_use(id))
                    a.status = STAT_BADSLOT;
                else
                begin
                    mdl_fed[j] = now;
                    // only a live feed revives; primary is left as it was
                    if (c == CMD_LIVE && mdl_stale[j])
                    begin
                        mdl_stale[j] = 1'b0;
                        a.changed = 1'b1;
                    end
                end
            end
            CMD_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (mdl_active[i] && !mdl_stale[i] && now >= mdl_fed[i] &&
                        (now - mdl_fed[i]) > {24'd0, mdl_timeout})
                    begin
                        mdl_stale[i] = 1'b1;
                        mdl_stale_at[i] = now;
                        a.changed = 1'b1;
                    end
                if (a.changed)
                    refresh_primary();
            end
            CMD_LOOKUP:
            begin
                if (k == 0)
                    a.status = STAT_FULL;
                else
                    a.slot = slot_of_key(k);
            end
            default:
            begin
            end
        endcase
        a.primary = mdl_primary;
    endtask

    task automatic add_row(input logic [2:0] c, input logic [KEY_W-1:0] k,
                           input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now,
                           input logic typed, input logic [ID_W-1:0] es,
                           input logic [1:0] est, input logic [ID_W-1:0] ep,
                           input logic ec);
        stim_row_t r;
        r.cmd = c;
        r.key = k;
        r.id = id;
        r.now = now;
        r.typed = typed;
        r.ans = '{slot: es, status: est, primary: ep, changed: ec};
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // row checked against the predictor only
    task automatic add_open(input logic [2:0] c, input logic [KEY_W-1:0] k,
                            input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now);
        add_row(c, k, id, now, 1'b0, 4'd0, 2'd0, 4'd0, 1'b0);
    endtask

    // called at a rising edge; leaves start high only when no gap follows
    task automatic issue_request(input stim_row_t r);
        answer_t a;
        int      gap;
        start <= 1'b1;
        cmd <= r.cmd;
        port_key <= r.key;
        slot_id <= r.id;
        now_us <= r.now;
        do
            @(posedge clk);
        while (busy);
        registry_predict(r.cmd, r.key, r.id, r.now, a);
        pending_answers.insert(pending_answers.size(), r.typed ? r.ans : a);
        if ($urandom_range(0, 49) == 0)
            burst_mode = !burst_mode;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_answers();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TMO_W-1:0] v);
        drain_answers();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        mdl_timeout = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: answer with no request outstanding, expected none, %s",
                         $time, $sformatf("actual slot %0d status %0d", slot_out, status));
                mismatch_count++;
            end
            else
            begin
                e = pending_answers.pop_front();
                check_field("slot_out", e.slot, slot_out);
                check_field("status", e.status, status);
                check_field("primary_slot", e.primary, primary_slot);
                check_field("changed", e.changed, changed);
            end
        end
    end

    initial
    begin
        #4000000;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        logic [KEY_W-1:0]  key_pool [0:11];
        logic [TIME_W-1:0] clock_now;
        logic [TMO_W-1:0]  tmo;
        stim_row_t         r;
        int                pick;

        registry_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, bad inputs
        add_row(CMD_LOOKUP, 32'h0, 4'd0, 48'd0, 1'b1, 4'd0, STAT_FULL, 4'd0, 1'b0);
        add_row(CMD_CLAIM, 32'h0, 4'd0, 48'd0, 1'b1, 4'd0, STAT_FULL, 4'd0, 1'b0);
        add_row(CMD_FREE, 32'h0, 4'd0, 48'd0, 1'b1, 4'd0, STAT_BADSLOT, 4'd0, 1'b0);
        add_row(CMD_TICK, 32'h0, 4'd0, 48'hFFFF_FFFF_FFFF, 1'b1, 4'd0, STAT_OK, 4'd0, 1'b0);
        add_row(CMD_CLAIM, 32'hFFFF_FFFF, 4'd0, 48'd0, 1'b1, 4'd1, STAT_OK, 4'd1, 1'b1);
        // claim of a live held key
        add_row(CMD_CLAIM, 32'hFFFF_FFFF, 4'd0, 48'd5, 1'b1, 4'd1, STAT_OK, 4'd1, 1'b0);
        add_open(CMD_CLAIM, 32'h1, 4'd0, 48'd0);
        for (int i = 3; i <= SLOTS; i++)
            add_open(CMD_CLAIM, 32'h1000_0000 + i, 4'd0, 48'd0);
        // every slot live
        add_row(CMD_CLAIM, 32'h2000_0000, 4'd0, 48'd0, 1'b1, 4'd0, STAT_FULL, 4'd1, 1'b0);
        add_open(CMD_LIVE, 32'h0, 4'd8, 48'd100);
        add_open(CMD_XPORT, 32'h0, 4'd1, 48'd291);
        add_open(CMD_TICK, 32'h0, 4'd0, 48'd1500001);
        add_open(CMD_LOOKUP, 32'hDEAD_BEEF, 4'd0, 48'd0);
        // evicts the earliest stale slot
        add_open(CMD_CLAIM, 32'h0BAD_0000, 4'd0, 48'd1500002);
        add_open(CMD_LIVE, 32'h0, 4'd3, 48'd1500003);
        add_open(CMD_XPORT, 32'h0, 4'd4, 48'd1500004);
        add_open(CMD_CLAIM, 32'h1000_0005, 4'd0, 48'd1500005);
        add_open(CMD_FREE, 32'h0, 4'd1, 48'd0);
        add_open(CMD_FREE, 32'h0, 4'd9, 48'd0);
        add_open(CMD_LIVE, 32'h0, 4'd15, 48'd0);
        add_open(3'd6, 32'hFFFF_FFFF, 4'd15, 48'hFFFF_FFFF_FFFF);
        add_open(3'd7, 32'h0, 4'd0, 48'd0);
        // time going backwards, then the far end of time
        add_open(CMD_TICK, 32'h0, 4'd0, 48'd0);
        add_open(CMD_TICK, 32'h0, 4'd0, 48'hFFFF_FFFF_FFFF);

        foreach (directed_rows[i])
            issue_request(directed_rows[i]);

        key_pool[0] = 32'hFFFF_FFFF;
        key_pool[1] = 32'h0000_0001;
        for (int i = 2; i < 12; i++)
            key_pool[i] = $urandom | 32'h1;
        clock_now = '0;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: tmo = 24'd1;
                1: tmo = 24'hFF_FFFF;
                2: tmo = TMO_W'($urandom_range(2, 1000));
                3: tmo = TIMEOUT_RESET;
                4: tmo = TMO_W'($urandom_range(1, 24'hFF_FFFF));
                default: tmo = TMO_W'($urandom_range(1, 50000));
            endcase
            write_timeout(tmo);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    r.cmd = CMD_CLAIM;
                else if (pick < 40)
                    r.cmd = CMD_FREE;
                else if (pick < 55)
                    r.cmd = CMD_LIVE;
                else if (pick < 65)
                    r.cmd = CMD_XPORT;
                else if (pick < 85)
                    r.cmd = CMD_TICK;
                else if (pick < 95)
                    r.cmd = CMD_LOOKUP;
                else
                    r.cmd = 3'($urandom_range(6, 7));

                pick = $urandom_range(0, 19);
                if (pick == 0)
                    r.key = '0;
                else if (pick == 1)
                    r.key = $urandom;
                else
                    r.key = key_pool[$urandom_range(0, 11)];

                if ($urandom_range(0, 9) == 0)
                    r.id = 4'($urandom_range(0, 15));
                else
                    r.id = 4'($urandom_range(1, SLOTS));

                pick = $urandom_range(0, 19);
                if (pick == 0)
                    clock_now = TIME_W'({$urandom, $urandom});
                else if (pick == 1)
                    clock_now = clock_now - $urandom_range(0, tmo);
                else if (pick < 10)
                    clock_now = clock_now + $urandom_range(tmo / 2, 2 * tmo);
                else
                    clock_now = clock_now + $urandom_range(0, tmo / 4 + 1);
                r.now = clock_now;
                r.typed = 1'b0;
                r.ans = '0;
                issue_request(r);
            end
        end

        drain_answers();
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

FILE: filelist.f
src/cssr_pkg.sv
src/cssr_cell.sv
src/clock_source_slot_registry_core.sv
tb/tb.sv
